/* hdl/ggc_pkg.sv */
package ggc_pkg;

   localparam int MaxNodes = 256;
   localparam int MaxEdges = 4096;
   localparam int NodeW = $clog2(MaxNodes);
   localparam int EdgeW = $clog2(MaxEdges);
   localparam int PtrW = EdgeW + 1;
   localparam int ColorW = NodeW + 1;
   localparam logic [ColorW-1:0] Uncolored = ColorW'(MaxNodes);

   typedef enum logic [2:0] {
      FUNC_ROW   = 3'd0,
      FUNC_NBR   = 3'd1,
      FUNC_ORDER = 3'd2,
      FUNC_RUN   = 3'd3,
      FUNC_READ  = 3'd4
   } func_type;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_COLOR = 1'b1;

endpackage

/* hdl/ggc_ram.sv */
module ggc_ram #(
   parameter int Depth = 256,
   parameter int Width = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/greedy_graph_coloring_core.sv */
// Loads (row start, neighbor, order) are written as they are accepted; a color read passes
// through S_READ to the result, a node index out of range goes straight to it; either may stall.
// A run sweeps the color and mark memories clear, then per visited node reads its order entry
// and row bounds, marks the colors of colored neighbors, picks the lowest unmarked color and
// clears the marks, and ends with the count beat. One item is handled at a time.
// Reset is synchronous; a clearing pass with req_ready low follows it.
module greedy_graph_coloring_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_index,
   input  logic [12:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [8:0]  rsp_result_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_node_count
);

   localparam int NW = ggc_pkg::NodeW;
   localparam int EW = ggc_pkg::EdgeW;
   localparam int PW = ggc_pkg::PtrW;
   localparam int CW = ggc_pkg::ColorW;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_CLEAR = 13'b0000000000010,
      S_ORD   = 13'b0000000000100,
      S_LO    = 13'b0000000001000,
      S_HI    = 13'b0000000010000,
      S_NBR   = 13'b0000000100000,
      S_NCOL  = 13'b0000001000000,
      S_MARK  = 13'b0000010000000,
      S_SCAN  = 13'b0000100000000,
      S_UNMK  = 13'b0001000000000,
      S_READ  = 13'b0010000000000,
      S_RSP   = 13'b0100000000000,
      S_NEXT  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [NW:0] vis_ff, vis_in;
   logic [NW-1:0] node_ff, node_in;
   logic [PW-1:0] k_ff, k_in, hi_ff, hi_in;
   logic any_ff, any_in;
   logic [NW-1:0] most_ff, most_in, pick_ff, pick_in, top_ff, top_in;
   logic [NW:0] scan_ff, scan_in;
   logic [CW-1:0] rval_ff, rval_in;
   logic rkind_ff, rkind_in;
   logic busy_ff;

   // Memories.
   logic rs_we; logic [NW:0] rs_wa, rs_ra; logic [12:0] rs_rd;
   logic nl_we; logic [EW-1:0] nl_ra; logic [NW-1:0] nl_rd;
   logic vo_we; logic [NW-1:0] vo_ra; logic [NW-1:0] vo_rd;
   logic nc_we; logic [NW-1:0] nc_wa, nc_ra; logic [CW-1:0] nc_wd, nc_rd;
   logic mk_we; logic [NW-1:0] mk_wa, mk_ra; logic mk_wd; logic mk_rd;

   ggc_ram #(.Depth(ggc_pkg::MaxNodes + 1), .Width(13)) u_rs (
      .clock, .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(req_value),
      .rd_addr(rs_ra), .rd_data(rs_rd));
   ggc_ram #(.Depth(ggc_pkg::MaxEdges), .Width(NW)) u_nl (
      .clock, .wr_en(nl_we), .wr_addr(req_index[EW-1:0]),
      .wr_data(req_value[NW-1:0]), .rd_addr(nl_ra), .rd_data(nl_rd));
   ggc_ram #(.Depth(ggc_pkg::MaxNodes), .Width(NW)) u_vo (
      .clock, .wr_en(vo_we), .wr_addr(req_index[NW-1:0]),
      .wr_data(req_value[NW-1:0]), .rd_addr(vo_ra), .rd_data(vo_rd));
   ggc_ram #(.Depth(ggc_pkg::MaxNodes), .Width(CW)) u_nc (
      .clock, .wr_en(nc_we), .wr_addr(nc_wa), .wr_data(nc_wd),
      .rd_addr(nc_ra), .rd_data(nc_rd));
   ggc_ram #(.Depth(ggc_pkg::MaxNodes), .Width(1)) u_mk (
      .clock, .wr_en(mk_we), .wr_addr(mk_wa), .wr_data(mk_wd),
      .rd_addr(mk_ra), .rd_data(mk_rd));

   logic req_fire;
   logic [CW-1:0] nmax;
   logic [PW-1:0] rs_clip;
   assign req_ready = (state_ff == S_IDLE) && busy_ff;
   assign csr_ready = 1'b1;
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_result_kind = rkind_ff;
   assign rsp_result_value = rval_ff;
   assign nmax = (count_ff > CW'(ggc_pkg::MaxNodes)) ? CW'(ggc_pkg::MaxNodes) : count_ff;
   assign rs_clip = (rs_rd > 13'(ggc_pkg::MaxEdges)) ? PW'(ggc_pkg::MaxEdges)
                                                     : rs_rd[PW-1:0];

   always_comb begin
      state_in = state_ff; vis_in = vis_ff; node_in = node_ff; k_in = k_ff;
      hi_in = hi_ff; any_in = any_ff; most_in = most_ff; pick_in = pick_ff;
      top_in = top_ff; scan_in = scan_ff;
      rval_in = rval_ff; rkind_in = rkind_ff;
      rs_we = 1'b0; rs_wa = req_index[NW:0]; rs_ra = '0;
      nl_we = 1'b0; nl_ra = k_ff[EW-1:0];
      vo_we = 1'b0; vo_ra = vis_ff[NW-1:0];
      nc_we = 1'b0; nc_wa = scan_ff[NW-1:0]; nc_wd = ggc_pkg::Uncolored;
      nc_ra = req_index[NW-1:0];
      mk_we = 1'b0; mk_wa = scan_ff[NW-1:0]; mk_wd = 1'b0; mk_ra = scan_ff[NW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  ggc_pkg::FUNC_ROW:
                     rs_we = (req_index <= 12'(ggc_pkg::MaxNodes));
                  ggc_pkg::FUNC_NBR: nl_we = 1'b1;
                  ggc_pkg::FUNC_ORDER: vo_we = (req_index < 12'(ggc_pkg::MaxNodes));
                  ggc_pkg::FUNC_RUN: begin
                     scan_in = '0; state_in = S_CLEAR;
                  end
                  ggc_pkg::FUNC_READ: begin
                     rkind_in = ggc_pkg::KIND_COLOR;
                     if (req_index < 12'(ggc_pkg::MaxNodes)) begin
                        state_in = S_READ;
                     end else begin
                        rval_in = ggc_pkg::Uncolored; state_in = S_RSP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rval_in = nc_rd; state_in = S_RSP;
         end
         S_CLEAR: begin
            nc_we = 1'b1; mk_we = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (NW+1)'(ggc_pkg::MaxNodes - 1)) begin
               vis_in = '0; top_in = '0; state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (vis_ff >= nmax) begin
               rkind_in = ggc_pkg::KIND_COUNT;
               rval_in = CW'(top_ff) + 1'b1; state_in = S_RSP;
            end else begin
               vo_ra = vis_ff[NW-1:0]; state_in = S_ORD;
            end
         end
         S_ORD: begin
            node_in = vo_rd; rs_ra = {1'b0, vo_rd}; state_in = S_LO;
         end
         S_LO: begin
            k_in = rs_rd[PW-1:0];
            if (rs_rd > 13'(ggc_pkg::MaxEdges)) k_in = PW'(ggc_pkg::MaxEdges);
            rs_ra = {1'b0, node_ff} + 1'b1; state_in = S_HI;
         end
         S_HI: begin
            hi_in = rs_clip; any_in = 1'b0; most_in = '0;
            nl_ra = k_ff[EW-1:0]; state_in = S_NBR;
         end
         S_NBR: begin
            if (k_ff >= hi_ff) begin
               pick_in = '0; state_in = any_ff ? S_SCAN : S_UNMK;
               mk_ra = '0; scan_in = '0;
            end else begin
               nl_ra = k_ff[EW-1:0]; state_in = S_NCOL;
            end
         end
         S_NCOL: begin
            nc_ra = nl_rd; state_in = S_MARK;
         end
         S_MARK: begin
            if (nc_rd != ggc_pkg::Uncolored) begin
               mk_we = 1'b1; mk_wa = nc_rd[NW-1:0]; mk_wd = 1'b1;
               if (!any_ff || nc_rd[NW-1:0] > most_ff) most_in = nc_rd[NW-1:0];
               any_in = 1'b1;
            end
            k_in = k_ff + 1'b1; nl_ra = k_in[EW-1:0]; state_in = S_NBR;
         end
         S_SCAN: begin
            // mk_rd holds the mark of pick_ff, whose address was issued last cycle.
            if ({1'b0, pick_ff} <= {1'b0, most_ff} && mk_rd &&
                pick_ff != NW'(ggc_pkg::MaxNodes - 1)) begin
               pick_in = pick_ff + 1'b1; mk_ra = pick_in;
               mk_we = 1'b1; mk_wa = pick_ff;
            end else begin
               scan_in = {1'b0, pick_ff}; state_in = S_UNMK;
            end
         end
         S_UNMK: begin
            // Clears marks up to most; entries below pick were cleared in scan.
            if (any_ff && scan_ff <= {1'b0, most_ff}) begin
               mk_we = 1'b1; mk_wa = scan_ff[NW-1:0]; scan_in = scan_ff + 1'b1;
            end else begin
               nc_we = 1'b1; nc_wa = node_ff; nc_wd = {1'b0, pick_ff};
               if (pick_ff > top_ff) top_in = pick_ff;
               vis_in = vis_ff + 1'b1; state_in = S_NEXT;
            end
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= CW'(1);
         busy_ff <= 1'b0;
         top_ff <= '0;
      end else begin
         state_ff <= state_in;
         top_ff <= top_in;
         if (state_ff == S_CLEAR && state_in == S_NEXT && !busy_ff) begin
            busy_ff <= 1'b1;
            state_ff <= S_IDLE;
         end
         if (csr_valid) count_ff <= csr_node_count;
      end
      vis_ff <= vis_in; node_ff <= node_in; k_ff <= k_in; hi_ff <= hi_in;
      any_ff <= any_in; most_ff <= most_in; pick_ff <= pick_in;
      scan_ff <= reset ? '0 : scan_in;
      rval_ff <= rval_in; rkind_ff <= rkind_in;
   end

endmodule

/* bench/tb_top.sv */
module tb_top;

   class ColoringScoreboard;
      logic [12:0] row_ptr [ggc_pkg::MaxNodes+1];
      logic [7:0]  nbr_node [ggc_pkg::MaxEdges];
      logic [7:0]  visit_node [ggc_pkg::MaxNodes];
      logic [8:0]  node_color [ggc_pkg::MaxNodes];
      bit          colored [ggc_pkg::MaxNodes];
      logic [8:0]  node_count = 9'd1;
      logic [9:0]  pending [$];
      int          errors = 0;

      function void expect_beat(logic [9:0] b);
         pending.insert(pending.size(), b);
      endfunction

      // Greedy pass over the visiting order, giving the number of colors.
      function logic [8:0] color_graph();
         int n, lo, hi, top, most, pick, nd;
         bit any;
         bit mark [ggc_pkg::MaxNodes];
         n = (node_count > ggc_pkg::MaxNodes) ? ggc_pkg::MaxNodes : node_count;
         top = 0;
         foreach (colored[j]) colored[j] = 0;
         for (int i = 0; i < n; i++) begin
            nd = visit_node[i];
            lo = row_ptr[nd];
            hi = row_ptr[nd+1];
            if (hi > ggc_pkg::MaxEdges) hi = ggc_pkg::MaxEdges;
            any = 0;
            most = 0;
            foreach (mark[j]) mark[j] = 0;
            for (int k = lo; k < hi; k++) begin
               if (colored[nbr_node[k]]) begin
                  if (!any || node_color[nbr_node[k]] > most) most = node_color[nbr_node[k]];
                  any = 1;
                  mark[node_color[nbr_node[k]]] = 1;
               end
            end
            pick = 0;
            if (any) while (pick <= most && mark[pick]) pick++;
            if (pick > ggc_pkg::MaxNodes - 1) pick = ggc_pkg::MaxNodes - 1;
            node_color[nd] = pick;
            colored[nd] = 1;
            if (pick > top) top = pick;
         end
         return 9'(top + 1);
      endfunction

      function void note_beat(logic [2:0] f, logic [11:0] idx, logic [12:0] v);
         case (f)
            ggc_pkg::FUNC_ROW:   if (idx <= ggc_pkg::MaxNodes) row_ptr[idx] = v;
            ggc_pkg::FUNC_NBR:   nbr_node[idx] = v[7:0];
            ggc_pkg::FUNC_ORDER: if (idx < ggc_pkg::MaxNodes) visit_node[idx] = v[7:0];
            ggc_pkg::FUNC_RUN:   expect_beat({ggc_pkg::KIND_COUNT, color_graph()});
            ggc_pkg::FUNC_READ: begin
               if (idx < ggc_pkg::MaxNodes && colored[idx])
                  expect_beat({ggc_pkg::KIND_COLOR, node_color[idx]});
               else
                  expect_beat({ggc_pkg::KIND_COLOR, ggc_pkg::Uncolored});
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic kind, logic [8:0] val);
         logic [9:0] exp_beat;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat kind %0d value %0d", $time, kind, val);
            errors++;
            return;
         end
         exp_beat = pending.pop_front();
         if (kind !== exp_beat[9]) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, exp_beat[9], kind);
            errors++;
         end
         if (val !== exp_beat[8:0]) begin
            $display("%0t: result_value expected %0d actual %0d", $time, exp_beat[8:0], val);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_func = ggc_pkg::FUNC_ROW;
   logic [11:0] req_index = 0;
   logic [12:0] req_value = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_result_kind;
   logic [8:0]  rsp_result_value;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [8:0]  csr_node_count = 9'd1;

   ColoringScoreboard sb = new();
   int burst_left = 0;
   int random_items = 0;
   int stall_mode = 0;
   int rsp_cycle = 0;

   greedy_graph_coloring_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_result_value(rsp_result_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_node_count(csr_node_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_result_kind, rsp_result_value);
      rsp_cycle++;
      if (rsp_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= (rsp_cycle % 8) != 0;
         default: rsp_ready <= ($urandom % 3) != 0;
      endcase
   end

   task automatic send(logic [2:0] f, logic [11:0] idx, logic [12:0] v);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_index <= idx;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(f, idx, v);
      random_items++;
   endtask

   // Loads give no result beat, so allow their pipeline to drain too.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(logic [8:0] n);
      wait_idle();
      csr_valid <= 1'b1;
      csr_node_count <= n;
      do @(posedge clock); while (!csr_ready);
      sb.node_count = n;
      csr_valid <= 1'b0;
   endtask

   // Order entries only ever name nodes 0..47 or 249..255, whose neighbor
   // ranges always lie on written neighbor entries.
   function automatic logic [12:0] safe_node(int k);
      if ($urandom_range(0, 15) == 0) return 13'($urandom_range(249, 255));
      return 13'($urandom_range(0, k - 1) | ($urandom_range(0, 31) << 8));
   endfunction

   task automatic graph_phase();
      int k, m, ptr, deg;
      logic [8:0] n;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
      ptr = 0;
      for (int j = 0; j <= k; j++) begin
         send(ggc_pkg::FUNC_ROW, 12'(j), 13'(ptr));
         deg = $urandom_range(0, 4);
         if (ptr + deg > 128) deg = 0;
         ptr += deg;
      end
      for (int e = 0; e < ptr; e++)
         send(ggc_pkg::FUNC_NBR, 12'(e),
              ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                          : 13'($urandom_range(0, k)));
      m = $urandom_range(1, k + 2);
      for (int i = 0; i < m; i++) send(ggc_pkg::FUNC_ORDER, 12'(i), safe_node(k));
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 4))
            0: send(3'd5 + 3'($urandom_range(0, 2)), 12'($urandom), 13'($urandom));
            1: send(ggc_pkg::FUNC_ROW, 12'($urandom_range(257, 4095)), 13'($urandom));
            2: send(ggc_pkg::FUNC_ORDER, 12'($urandom_range(256, 4095)), 13'($urandom));
            default: send(ggc_pkg::FUNC_READ, 12'($urandom_range(0, 4095)), 13'($urandom));
         endcase
      end
      case ($urandom_range(0, 19))
         0: n = 0;
         1: n = 256;
         2: n = 511;
         3: n = 9'($urandom_range(0, 511));
         default: n = 9'(m);
      endcase
      write_node_count(n);
      send(ggc_pkg::FUNC_RUN, 12'($urandom), 13'($urandom));
      repeat ($urandom_range(1, 6))
         send(ggc_pkg::FUNC_READ,
              ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, k + 2)),
              13'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Nothing is colored yet, and node count is still 1.
      send(ggc_pkg::FUNC_READ, 12'd0, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd4095, 13'd8191);
      // Full pointer table: empty rows, plus equal, inverted and capped ranges
      // at the top end of the table.
      for (int j = 0; j <= 248; j++) send(ggc_pkg::FUNC_ROW, 12'(j), 13'd0);
      send(ggc_pkg::FUNC_ROW, 12'd249, 13'd8191);
      send(ggc_pkg::FUNC_ROW, 12'd250, 13'd8191);
      send(ggc_pkg::FUNC_ROW, 12'd251, 13'd8191);
      send(ggc_pkg::FUNC_ROW, 12'd252, 13'd4096);
      send(ggc_pkg::FUNC_ROW, 12'd253, 13'd4090);
      send(ggc_pkg::FUNC_ROW, 12'd254, 13'd8191);
      send(ggc_pkg::FUNC_ROW, 12'd255, 13'd8191);
      send(ggc_pkg::FUNC_ROW, 12'd256, 13'd8191);
      for (int e = 0; e < 128; e++)
         send(ggc_pkg::FUNC_NBR, 12'(e), 13'($urandom_range(0, 8191)));
      for (int e = 4090; e < 4096; e++)
         send(ggc_pkg::FUNC_NBR, 12'(e), 13'($urandom_range(0, 255)));
      for (int i = 0; i < 256; i++) send(ggc_pkg::FUNC_ORDER, 12'(i), safe_node(48));
      send(ggc_pkg::FUNC_RUN, 12'd0, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd0, 13'd0);
      write_node_count(9'd256);
      send(ggc_pkg::FUNC_RUN, 12'd0, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd253, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd255, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd256, 13'd0);
      write_node_count(9'd0);
      send(ggc_pkg::FUNC_RUN, 12'd0, 13'd0);
      send(ggc_pkg::FUNC_READ, 12'd1, 13'd0);
      send(3'd7, 12'd4095, 13'd8191);
      while (random_items < 1550) graph_phase();
      wait_idle();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #100000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
